// ===== rtl/okfe_pkg.sv =====
package okfe_pkg;

    localparam int DATA_BITS = 56;
    localparam int PKT_IX_W  = 6;
    localparam int NUM_REGS  = 8;

    localparam logic [16:0] LEAD_IN_US = 17'd100000;
    localparam logic [24:0] TRAIL_US   = 25'd30000000;
    localparam logic [6:0]  SIGNATURE  = 7'h44;

    typedef logic [DATA_BITS-1:0] packet_t;

    typedef enum logic [2:0] {
        REG_SAMPLES_PER_US = 3'd0,
        REG_SYNC_HIGH      = 3'd1,
        REG_SYNC_LOW       = 3'd2,
        REG_ONE_HIGH       = 3'd3,
        REG_ONE_LOW        = 3'd4,
        REG_ZERO_HIGH      = 3'd5,
        REG_ZERO_LOW       = 3'd6,
        REG_STOP_HIGH      = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        PK_SYNC = 2'd0,
        PK_ZERO = 2'd1,
        PK_ONE  = 2'd2,
        PK_STOP = 2'd3
    } pulse_kind_t;

    typedef struct packed {
        logic [6:0]  samples_per_us;
        logic [15:0] sync_high_us;
        logic [15:0] sync_low_us;
        logic [15:0] one_high_us;
        logic [15:0] one_low_us;
        logic [15:0] zero_high_us;
        logic [15:0] zero_low_us;
        logic [15:0] stop_high_us;
    } cfg_t;

endpackage

// ===== rtl/ook_pulse_width_frame_encoder_core.sv =====
// Pulse-width OOK frame encoder. Each s_tdata transaction is one frame request; it
// produces SYNC_PULSES + 57 pulse transactions on the m side (61 by default): sync
// pulses, 56 packet bits MSB first, and a stop pulse flagged with m_tlast. The pulse
// sequencer emits one pulse per cycle while m_tready stays high; a two-entry request
// queue lets the next frame be accepted while the current one plays out. Durations are
// the microsecond registers (or the LEAD_IN_US and TRAIL_US constants) times
// samples_per_us. Write configuration only while no frame is in flight.
module ook_pulse_width_frame_encoder_core #(
    parameter int SYNC_PULSES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // lead_value, id_low, humidity, temp_high, temp_low, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // pre_low_samples, high_samples, low_samples, pad
    output logic [1:0]  m_tuser,    // pulse_kind
    output logic        m_tlast
);

    okfe_pkg::cfg_t    cfg_reg;
    okfe_pkg::packet_t packet;
    okfe_pkg::packet_t head;
    logic              full;
    logic              empty;
    logic              push;
    logic              pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_us <= 7'd1;
            cfg_reg.sync_high_us   <= 16'd662;
            cfg_reg.sync_low_us    <= 16'd564;
            cfg_reg.one_high_us    <= 16'd436;
            cfg_reg.one_low_us     <= 16'd180;
            cfg_reg.zero_high_us   <= 16'd245;
            cfg_reg.zero_low_us    <= 16'd366;
            cfg_reg.stop_high_us   <= 16'd100;
        end
        else if (cfg_valid)
        begin
            case (okfe_pkg::reg_index_t'(cfg_index))
                okfe_pkg::REG_SAMPLES_PER_US: cfg_reg.samples_per_us <= cfg_data[6:0];
                okfe_pkg::REG_SYNC_HIGH:      cfg_reg.sync_high_us   <= cfg_data;
                okfe_pkg::REG_SYNC_LOW:       cfg_reg.sync_low_us    <= cfg_data;
                okfe_pkg::REG_ONE_HIGH:       cfg_reg.one_high_us    <= cfg_data;
                okfe_pkg::REG_ONE_LOW:        cfg_reg.one_low_us     <= cfg_data;
                okfe_pkg::REG_ZERO_HIGH:      cfg_reg.zero_high_us   <= cfg_data;
                okfe_pkg::REG_ZERO_LOW:       cfg_reg.zero_low_us    <= cfg_data;
                okfe_pkg::REG_STOP_HIGH:      cfg_reg.stop_high_us   <= cfg_data;
                default:                      cfg_reg.stop_high_us   <= cfg_reg.stop_high_us;
            endcase
        end
    end

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    okfe_front u_front (
        .lead_value (s_tdata[7:0]),
        .id_low     (s_tdata[14:8]),
        .humidity   (s_tdata[21:15]),
        .temp_high  (s_tdata[28:22]),
        .temp_low   (s_tdata[35:29]),
        .packet     (packet)
    );

    okfe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (packet),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    okfe_back #(
        .SYNC_PULSES (SYNC_PULSES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_avail (!empty),
        .frame       (head),
        .frame_done  (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== rtl/okfe_front.sv =====
module okfe_front (
    input  logic [7:0]       lead_value,
    input  logic [6:0]       id_low,
    input  logic [6:0]       humidity,
    input  logic [6:0]       temp_high,
    input  logic [6:0]       temp_low,
    output okfe_pkg::packet_t packet
);

    function automatic logic [7:0] with_parity(input logic [6:0] v);
        return {^v, v};
    endfunction

    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] csum;

    always_comb
    begin
        b1   = with_parity(id_low);
        b2   = with_parity(okfe_pkg::SIGNATURE);
        b3   = with_parity(humidity);
        b4   = with_parity(temp_high);
        b5   = with_parity(temp_low);
        csum = lead_value + b1 + b2 + b3 + b4 + b5;
    end

    assign packet = {lead_value, b1, b2, b3, b4, b5, csum};

endmodule

// ===== rtl/okfe_fifo.sv =====
module okfe_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  okfe_pkg::packet_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output okfe_pkg::packet_t head
);

    okfe_pkg::packet_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/okfe_back.sv =====
module okfe_back #(
    parameter int SYNC_PULSES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  okfe_pkg::cfg_t    cfg,
    input  logic              frame_avail,
    input  okfe_pkg::packet_t frame,
    output logic              frame_done,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,   // pre_low_samples, high_samples, low_samples, pad
    output logic [1:0]        m_tuser,   // pulse_kind
    output logic              m_tlast
);

    localparam int PULSES = SYNC_PULSES + okfe_pkg::DATA_BITS + 1;
    localparam int CW     = $clog2(PULSES);

    logic [CW-1:0] pulse_ix_reg;
    logic [CW-1:0] pulse_ix_next;
    logic          valid_reg;
    logic          valid_next;
    logic [23:0]   pre_reg;
    logic [22:0]   high_reg;
    logic [31:0]   low_reg;
    logic [1:0]    kind_reg;
    logic          last_reg;

    logic                    advance;
    logic                    is_sync;
    logic                    is_stop;
    logic [CW-1:0]           data_off;
    logic [okfe_pkg::PKT_IX_W-1:0] bit_ix;
    logic                    data_bit;
    okfe_pkg::pulse_kind_t   kind;
    logic [15:0]             high_us;
    logic [24:0]             low_us;
    logic [23:0]             pre_val;
    logic [22:0]             high_val;
    logic [31:0]             low_val;

    assign advance = frame_avail && (!valid_reg || m_tready);
    assign is_sync = (pulse_ix_reg < CW'(SYNC_PULSES));
    assign is_stop = (pulse_ix_reg == CW'(PULSES - 1));
    assign data_off = pulse_ix_reg - CW'(SYNC_PULSES);
    assign bit_ix  = okfe_pkg::PKT_IX_W'(okfe_pkg::DATA_BITS - 1)
                     - data_off[okfe_pkg::PKT_IX_W-1:0];
    assign data_bit = frame[bit_ix];
    assign frame_done = advance && is_stop;

    always_comb
    begin
        if (is_sync)
        begin
            kind    = okfe_pkg::PK_SYNC;
            high_us = cfg.sync_high_us;
            low_us  = {9'd0, cfg.sync_low_us};
        end
        else if (is_stop)
        begin
            kind    = okfe_pkg::PK_STOP;
            high_us = cfg.stop_high_us;
            low_us  = okfe_pkg::TRAIL_US;
        end
        else if (data_bit)
        begin
            kind    = okfe_pkg::PK_ONE;
            high_us = cfg.one_high_us;
            low_us  = {9'd0, cfg.one_low_us};
        end
        else
        begin
            kind    = okfe_pkg::PK_ZERO;
            high_us = cfg.zero_high_us;
            low_us  = {9'd0, cfg.zero_low_us};
        end
        pre_val  = (pulse_ix_reg == '0)
                   ? 24'(cfg.samples_per_us) * 24'(okfe_pkg::LEAD_IN_US) : 24'd0;
        high_val = 23'(cfg.samples_per_us) * 23'(high_us);
        low_val  = 32'(cfg.samples_per_us) * 32'(low_us);
    end

    always_comb
    begin
        pulse_ix_next = pulse_ix_reg;
        valid_next    = valid_reg;
        if (advance)
        begin
            pulse_ix_next = is_stop ? '0 : pulse_ix_reg + 1'b1;
            valid_next    = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ix_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            pulse_ix_reg <= pulse_ix_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pre_reg  <= pre_val;
            high_reg <= high_val;
            low_reg  <= low_val;
            kind_reg <= kind;
            last_reg <= is_stop;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, low_reg, high_reg, pre_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== sim/ook_pulse_width_frame_encoder_core_tb.sv =====
`timescale 1ns / 100ps

module ook_pulse_width_frame_encoder_core_tb;

    localparam int SYNC_COUNT  = 4;
    localparam int MAX_REPORTS = 10;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int ITEMS_PER_SETTING = 30;

    typedef struct packed {
        logic [6:0] temp_low;
        logic [6:0] temp_high;
        logic [6:0] humidity;
        logic [6:0] id_low;
        logic [7:0] lead_value;
    } frame_t;

    typedef struct packed {
        logic [23:0]           pre_low;
        logic [22:0]           high;
        logic [31:0]           low;
        okfe_pkg::pulse_kind_t kind;
        logic                  last;
    } pulse_t;

    class pulse_scoreboard;
        okfe_pkg::cfg_t regs;
        pulse_t         expected_q[$];
        int             mismatches = 0;

        function void load_defaults();
            regs.samples_per_us = 7'd1;
            regs.sync_high_us   = 16'd662;
            regs.sync_low_us    = 16'd564;
            regs.one_high_us    = 16'd436;
            regs.one_low_us     = 16'd180;
            regs.zero_high_us   = 16'd245;
            regs.zero_low_us    = 16'd366;
            regs.stop_high_us   = 16'd100;
        endfunction

        function void write_reg(okfe_pkg::reg_index_t idx, logic [15:0] d);
            case (idx)
                okfe_pkg::REG_SAMPLES_PER_US: regs.samples_per_us = d[6:0];
                okfe_pkg::REG_SYNC_HIGH:      regs.sync_high_us   = d;
                okfe_pkg::REG_SYNC_LOW:       regs.sync_low_us    = d;
                okfe_pkg::REG_ONE_HIGH:       regs.one_high_us    = d;
                okfe_pkg::REG_ONE_LOW:        regs.one_low_us     = d;
                okfe_pkg::REG_ZERO_HIGH:      regs.zero_high_us   = d;
                okfe_pkg::REG_ZERO_LOW:       regs.zero_low_us    = d;
                okfe_pkg::REG_STOP_HIGH:      regs.stop_high_us   = d;
                default: ;
            endcase
        endfunction

        // builds the 7-byte packet and queues every pulse of the frame
        function void note_frame(frame_t f);
            logic [7:0]  pkt [7];
            logic [7:0]  chk;
            logic [63:0] spu, lead_in, trail, sh, sl, oh, ol, zh, zl, st;
            pulse_t      p;
            logic        bit_val;
            int          i;
            int          n;
            pkt[0] = f.lead_value;
            pkt[1] = {^f.id_low, f.id_low};
            pkt[2] = {^okfe_pkg::SIGNATURE, okfe_pkg::SIGNATURE};
            pkt[3] = {^f.humidity, f.humidity};
            pkt[4] = {^f.temp_high, f.temp_high};
            pkt[5] = {^f.temp_low, f.temp_low};
            chk = 8'd0;
            for (i = 0; i < 6; i++)
                chk += pkt[i];
            pkt[6] = chk;

            spu     = {57'd0, regs.samples_per_us};
            lead_in = spu * okfe_pkg::LEAD_IN_US;
            trail   = spu * okfe_pkg::TRAIL_US;
            sh = spu * regs.sync_high_us;
            sl = spu * regs.sync_low_us;
            oh = spu * regs.one_high_us;
            ol = spu * regs.one_low_us;
            zh = spu * regs.zero_high_us;
            zl = spu * regs.zero_low_us;
            st = spu * regs.stop_high_us;

            n = 0;
            for (i = 0; i < SYNC_COUNT; i++)
            begin
                p.pre_low = (n == 0) ? lead_in[23:0] : 24'd0;
                p.high    = sh[22:0];
                p.low     = sl[31:0];
                p.kind    = okfe_pkg::PK_SYNC;
                p.last    = 1'b0;
                expected_q.push_back(p);
                n++;
            end
            for (i = 0; i < okfe_pkg::DATA_BITS; i++)
            begin
                bit_val   = pkt[i / 8][7 - (i % 8)];
                p.pre_low = (n == 0) ? lead_in[23:0] : 24'd0;
                p.high    = bit_val ? oh[22:0] : zh[22:0];
                p.low     = bit_val ? ol[31:0] : zl[31:0];
                p.kind    = bit_val ? okfe_pkg::PK_ONE : okfe_pkg::PK_ZERO;
                p.last    = 1'b0;
                expected_q.push_back(p);
                n++;
            end
            p.pre_low = (n == 0) ? lead_in[23:0] : 24'd0;
            p.high    = st[22:0];
            p.low     = trail[31:0];
            p.kind    = okfe_pkg::PK_STOP;
            p.last    = 1'b1;
            expected_q.push_back(p);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_pulse(pulse_t got);
            pulse_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pulse: pre=%0d high=%0d low=%0d kind=%0d last=%0d",
                             got.pre_low, got.high, got.low, got.kind, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("pulse mismatch: exp pre=%0d high=%0d low=%0d kind=%0d last=%0d",
                             want.pre_low, want.high, want.low, want.kind, want.last);
                    $display("                got pre=%0d high=%0d low=%0d kind=%0d last=%0d",
                             got.pre_low, got.high, got.low, got.kind, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    pulse_scoreboard sb;
    int          send_idle_pct;
    int          rcv_idle_pct;
    logic [15:0] cfg_words [okfe_pkg::NUM_REGS];

    ook_pulse_width_frame_encoder_core #(
        .SYNC_PULSES (SYNC_COUNT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge clk)
    begin
        pulse_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pre_low = m_tdata[23:0];
            got.high    = m_tdata[46:24];
            got.low     = m_tdata[78:47];
            got.kind    = okfe_pkg::pulse_kind_t'(m_tuser);
            got.last    = m_tlast;
            sb.check_pulse(got);
        end
    end

    function automatic frame_t make_frame(logic [7:0] lead, logic [6:0] id,
                                          logic [6:0] hum, logic [6:0] th, logic [6:0] tl);
        frame_t f;
        f.lead_value = lead;
        f.id_low     = id;
        f.humidity   = hum;
        f.temp_high  = th;
        f.temp_low   = tl;
        return f;
    endfunction

    function automatic frame_t random_frame();
        return make_frame(8'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                          7'($urandom));
    endfunction

    function automatic logic [15:0] random_duration();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, f};
        do @(posedge clk); while (!s_tready);
        sb.note_frame(f);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_config();
        int i;
        for (i = 0; i < okfe_pkg::NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= cfg_words[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(okfe_pkg::reg_index_t'(i[2:0]), cfg_words[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_uniform(input logic [15:0] spu_word, input logic [15:0] us);
        int i;
        drain();
        cfg_words[0] = spu_word;
        for (i = 1; i < okfe_pkg::NUM_REGS; i++)
            cfg_words[i] = us;
        write_config();
    endtask

    task automatic set_random();
        int i;
        drain();
        case ($urandom_range(5))
            0:       cfg_words[0][6:0] = 7'd0;
            1:       cfg_words[0][6:0] = 7'd127;
            2:       cfg_words[0][6:0] = 7'd100;
            default: cfg_words[0][6:0] = 7'($urandom_range(1, 127));
        endcase
        cfg_words[0][15:7] = 9'($urandom);
        for (i = 1; i < okfe_pkg::NUM_REGS; i++)
            cfg_words[i] = random_duration();
        write_config();
    endtask

    initial
    begin
        int phase;
        int j;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = 3'd0;
        cfg_data      = 16'd0;
        s_tvalid      = 1'b0;
        s_tdata       = 40'd0;
        m_tready      = 1'b0;
        send_idle_pct = 33;
        rcv_idle_pct  = 51;
        sb = new;
        sb.load_defaults();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings
        send_frame(make_frame(8'h00, 7'h00, 7'h00, 7'h00, 7'h00));
        send_frame(make_frame(8'hFF, 7'h7F, 7'h7F, 7'h7F, 7'h7F));
        send_frame(make_frame(8'hAA, 7'h55, 7'h2A, 7'h55, 7'h2A));
        send_frame(make_frame(8'h55, 7'h2A, 7'h55, 7'h2A, 7'h55));
        send_frame(make_frame(8'h80, 7'h01, 7'h40, 7'h03, 7'h7E));
        send_frame(make_frame(8'h01, 7'h40, 7'h01, 7'h7E, 7'h03));
        send_frame(make_frame(8'hF0, 7'h0F, 7'h70, 7'h07, 7'h38));
        send_frame(make_frame(8'h0F, 7'h70, 7'h0F, 7'h38, 7'h07));

        // zero rate, with junk above the rate field
        set_uniform(16'hFF80, 16'hFFFF);
        send_frame(make_frame(8'hFF, 7'h7F, 7'h7F, 7'h7F, 7'h7F));
        send_frame(make_frame(8'h00, 7'h00, 7'h00, 7'h00, 7'h00));
        send_frame(make_frame(8'h3C, 7'h5A, 7'h21, 7'h66, 7'h19));

        // largest rate and durations
        set_uniform(16'h007F, 16'hFFFF);
        send_frame(make_frame(8'hFF, 7'h7F, 7'h7F, 7'h7F, 7'h7F));
        send_frame(make_frame(8'h00, 7'h00, 7'h00, 7'h00, 7'h00));
        send_frame(make_frame(8'hC3, 7'h24, 7'h5B, 7'h11, 7'h6E));

        set_uniform(16'h0001, 16'h0001);
        send_frame(make_frame(8'hA5, 7'h33, 7'h4C, 7'h0A, 7'h75));
        send_frame(make_frame(8'h5A, 7'h4C, 7'h33, 7'h75, 7'h0A));

        set_uniform(16'h0064, 16'h0000);
        send_frame(make_frame(8'h7E, 7'h7F, 7'h00, 7'h7F, 7'h00));
        send_frame(make_frame(8'h81, 7'h00, 7'h7F, 7'h00, 7'h7F));

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    rcv_idle_pct  = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    rcv_idle_pct  = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
            endcase
            for (j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                if (j % ITEMS_PER_SETTING == 0)
                    set_random();
                send_frame(random_frame());
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.pending() != 0)
            $display("%0d expected pulses never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
